// ----- src/tdf_pkg.sv -----
// Package for the trial-division factor block: sequencer state codes and
// the status group passed from the serial divider to the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdf_pkg;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } tdf_state_t;

  // Divider status, meaningful in the cycle that done is high.
  typedef struct packed {
    logic done;
    logic rem_zero;
    logic quo_lt_div;
  } tdf_div_stat_t;

endpackage

`default_nettype wire

// ----- src/tdf_serial_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdf_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module tdf_serial_div
  import tdf_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output logic      [DATA_WIDTH-1:0] quotient,
  output tdf_div_stat_t              stat
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic                  running;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] shreg;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] quo_next;

  // rem < divisor always, so the shifted partial remainder fits in W+1 bits
  always_comb begin
    rem_sh   = {rem, shreg[DATA_WIDTH-1]};
    diff     = rem_sh - {1'b0, divisor};
    fits     = ~diff[DATA_WIDTH];
    rem_next = fits ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
    quo_next = {quo[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      quo   <= '0;
    end else if (running) begin
      shreg <= {shreg[DATA_WIDTH-2:0], 1'b0};
      rem   <= rem_next;
      quo   <= quo_next;
    end
  end

  assign quotient        = quo;
  assign stat.done       = done;
  assign stat.rem_zero   = (rem == '0);
  assign stat.quo_lt_div = (quo < divisor);

endmodule

`default_nettype wire

// ----- src/trial_division_factor.sv -----
// Channel   Ports                                  Handshake
// input     number                                 start & !busy accepts the word
// result    small_factor, large_factor             done high for one cycle
//
// Candidates 2, 3, 5, 7, 9, ... (2, then every odd number) are tried in turn
// in the bit-serial divider. The scan ends on the first zero remainder or
// once quotient < candidate; numbers below 4 answer without a division, with
// done high in the cycle after start. Reset is synchronous and clears only
// control state. The receiver cannot stall; busy holds off start.
// Depends on tdf_pkg and tdf_serial_div.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_factor
  import tdf_pkg::*;
#(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] number,
  output logic                       busy,
  output logic                       done,
  output logic      [DATA_WIDTH-1:0] small_factor,
  output logic      [DATA_WIDTH-1:0] large_factor
);

  tdf_state_t            state;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] num;
  logic [DATA_WIDTH-1:0] cand;
  logic [DATA_WIDTH-1:0] quo;
  tdf_div_stat_t         stat;

  tdf_serial_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (cand),
    .quotient (quo),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      div_start <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (number < DATA_WIDTH'(4)) begin
              done <= 1'b1;
            end else begin
              div_start <= 1'b1;
              state     <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (stat.done) begin
            if (stat.rem_zero || stat.quo_lt_div) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              div_start <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      num  <= number;
      cand <= DATA_WIDTH'(2);
      if (number < DATA_WIDTH'(4)) begin
        small_factor <= DATA_WIDTH'(1);
        large_factor <= number;
      end
    end else if (state == S_RUN && stat.done) begin
      if (stat.rem_zero) begin
        small_factor <= cand;
        large_factor <= quo;
      end else if (stat.quo_lt_div) begin
        // candidate passed sqrt(num): no factor, num is prime
        small_factor <= DATA_WIDTH'(1);
        large_factor <= num;
      end else begin
        cand <= (cand == DATA_WIDTH'(2)) ? DATA_WIDTH'(3) : cand + DATA_WIDTH'(2);
      end
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

// ----- src/tdf_checker.sv -----
// Port-level checker for trial_division_factor, with its bind statement.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none

module tdf_checker #(
  parameter int DATA_WIDTH = 64
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done,
  input wire logic [DATA_WIDTH-1:0] small_factor
);

  // a result word comes out only with the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted word either starts a scan or answers at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word dropped");

  // every finished scan delivers a result word
  a_end_scan: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("scan ended without result");

  // small factor is never zero when done is high
  a_small_nz: assert property (@(posedge clk) disable iff (rst)
    done |-> (small_factor != '0))
    else $error("zero small factor");

  a_reset: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("reset did not clear control");

endmodule

bind trial_division_factor tdf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tdf_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .small_factor(small_factor)
);

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for trial_division_factor: directed small, prime and extreme words,
// then random words, mostly multiples of small primes, under several sender idle rates.
// Depends on the trial_division_factor RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int W = 64;
  localparam int DRAIN_CYCLES = 20000;
  localparam int N_PRIMES = 54;

  typedef struct {
    logic [W-1:0] number;
    logic [W-1:0] lo_factor;
    logic [W-1:0] hi_factor;
  } factor_pair_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic [W-1:0] number = '0;
  logic         busy;
  logic         done;
  logic [W-1:0] small_factor;
  logic [W-1:0] large_factor;

  factor_pair_t factor_q[$];
  int           fail_count = 0;
  int           idle_pct = 0;

  int unsigned  small_primes[N_PRIMES] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
    73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137, 139, 149, 151,
    157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229, 233,
    239, 241, 251
  };

  trial_division_factor #(
    .DATA_WIDTH(W)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .number      (number),
    .busy        (busy),
    .done        (done),
    .small_factor(small_factor),
    .large_factor(large_factor)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("trial_division_factor verification failed");
    $finish;
  end

  // Plain upward scan; stimulus keeps the smallest factor or the root small.
  function automatic factor_pair_t predict_factors(input logic [W-1:0] n);
    factor_pair_t fp;
    logic [W-1:0] d;
    logic         found;
    fp.number = n;
    fp.lo_factor = W'(1);
    fp.hi_factor = n;
    found = 1'b0;
    if (n >= W'(4)) begin
      for (d = W'(2); !found && d <= n / d; d++) begin
        if (n % d == '0) begin
          fp.lo_factor = d;
          fp.hi_factor = n / d;
          found = 1'b1;
        end
      end
    end
    return fp;
  endfunction

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Entered at a falling edge; returns at the falling edge after acceptance.
  task automatic send_number(input logic [W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      number <= {$urandom, $urandom};
      @(negedge clk);
    end
    start <= 1'b1;
    number <= n;
    do @(posedge clk); while (busy);
    factor_q.push_back(predict_factors(n));
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    factor_pair_t exp_fp;
    if (!rst && done) begin
      if (factor_q.size() == 0) begin
        flag_failure($sformatf("result word with nothing pending: %0d %0d",
                               small_factor, large_factor));
      end else begin
        exp_fp = factor_q.pop_front();
        if (small_factor !== exp_fp.lo_factor || large_factor !== exp_fp.hi_factor)
          flag_failure($sformatf("number %0d: expected %0d * %0d, got %0d * %0d",
                                 exp_fp.number, exp_fp.lo_factor, exp_fp.hi_factor,
                                 small_factor, large_factor));
      end
    end
  end

  // Mostly multiples of a small prime, skewed toward the smallest ones.
  function automatic logic [W-1:0] random_number();
    logic [W-1:0] r;
    int unsigned  p;
    r = {$urandom, $urandom};
    if ($urandom_range(9) == 0) return W'($urandom_range(2000));
    p = small_primes[$urandom_range(0, $urandom_range(0, N_PRIMES - 1))];
    return r - (r % W'(p));
  endfunction

  task automatic test_tiny_numbers();
    for (int i = 0; i < 10; i++) send_number(W'(i));
  endtask

  task automatic test_primes();
    send_number(64'd11);
    send_number(64'd97);
    send_number(64'd1021);
    send_number(64'd1031);
    send_number(64'd10007);
    send_number(64'd65521);
  endtask

  task automatic test_extremes();
    send_number(64'hFFFF_FFFF_FFFF_FFFF);
    send_number(64'hFFFF_FFFF_FFFF_FFFE);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'h8000_0000_0000_0001);
    send_number(64'h5555_5555_5555_5555);
    send_number(64'd63001);  // square of a prime
    send_number(64'd64507);  // two neighboring primes
  endtask

  task automatic test_random(input int count, input int pct);
    idle_pct = pct;
    repeat (count) send_number(random_number());
  endtask

  initial begin : main
    int waited;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_tiny_numbers();
    test_primes();
    test_extremes();
    test_random(30, 0);
    test_random(30, 80);
    test_random(20, 30);
    start <= 1'b0;
    waited = 0;
    while (factor_q.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (factor_q.size() != 0)
      flag_failure($sformatf("%0d words never returned", factor_q.size()));
    if (fail_count == 0) begin
      $display("trial_division_factor verification clean");
    end else begin
      $display("trial_division_factor verification failed");
    end
    $finish;
  end

endmodule
